FILE: rtl/gmon_pkg.sv
// gmon_pkg: shared widths, constants, register indexes and controller types
// for the presence gated gas monitor; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gmon_pkg;

   localparam int unsigned TIME_W     = 32;
   localparam int unsigned SAMPLE_W   = 12;
   localparam int unsigned ALPHA_W    = 9;
   localparam int unsigned FLOOR_W    = 15;
   localparam int unsigned CHG_W      = 16;
   localparam int unsigned ACHG_W     = 15;
   localparam int unsigned LVL_W      = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam int unsigned ACTIVE_DEADBAND = 4;
   localparam int unsigned IDLE_DEADBAND   = 16;
   localparam int unsigned ACTIVE_GAIN_Q4  = 16;
   localparam int unsigned IDLE_GAIN_Q4    = 16;
   localparam int unsigned AMMONIA_GAIN_Q4 = 16;

   // gain folded into the scale of one thousand, in tenths of a per-cent
   localparam int unsigned K_W     = 18;
   localparam int unsigned PROD_W  = SAMPLE_W + K_W;
   localparam int unsigned NFP_W   = FLOOR_W + SAMPLE_W;
   localparam int unsigned QUO_W   = 16;
   localparam int unsigned NUM_W   = 32;
   localparam int unsigned DEN_W   = SAMPLE_W + 5;
   localparam int unsigned FSUM_W  = 21;

   localparam logic [K_W-1:0] AMM_K    = K_W'(1000 * AMMONIA_GAIN_Q4);
   localparam logic [K_W-1:0] ACTIVE_K = K_W'(1000 * ACTIVE_GAIN_Q4);
   localparam logic [K_W-1:0] IDLE_K   = K_W'(1000 * IDLE_GAIN_Q4);

   // level thresholds in tenths, scaled by the Q4 denominator
   localparam logic [13:0] LVL1_K = 14'(100 * 16);
   localparam logic [13:0] LVL2_K = 14'(300 * 16);
   localparam logic [13:0] LVL3_K = 14'(800 * 16);

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

   localparam logic [SAMPLE_W-1:0] RST_AMM_BASE    = '0;
   localparam logic [SAMPLE_W-1:0] RST_AIR_BASE    = '0;
   localparam logic [TIME_W-1:0]   RST_IGNORE_MS   = TIME_W'(10000);
   localparam logic [TIME_W-1:0]   RST_POST_MS     = TIME_W'(30000);
   localparam logic [TIME_W-1:0]   RST_BOOST_MS    = TIME_W'(10000);
   localparam logic [ALPHA_W-1:0]  RST_ACT_ALPHA   = ALPHA_W'(128);
   localparam logic [ALPHA_W-1:0]  RST_IDLE_ALPHA  = ALPHA_W'(32);
   localparam logic [FLOOR_W-1:0]  RST_NOISE_FLOOR = FLOOR_W'(50);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AMM_BASE    = 3'd0,
      CSR_AIR_BASE    = 3'd1,
      CSR_IGNORE_MS   = 3'd2,
      CSR_POST_MS     = 3'd3,
      CSR_BOOST_MS    = 3'd4,
      CSR_ACT_ALPHA   = 3'd5,
      CSR_IDLE_ALPHA  = 3'd6,
      CSR_NOISE_FLOOR = 3'd7
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REC,
      ST_MODE,
      ST_FMUL,
      ST_FADD,
      ST_NUM,
      ST_LVL,
      ST_DIVA,
      ST_WAITA,
      ST_DIVB,
      ST_WAITB,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic load_in;
      logic rec_upd;
      logic mode_upd;
      logic fmul;
      logic fadd;
      logic num;
      logic lvl;
      logic div_start;
      logic div_air;
      logic amm_capture;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/gmon_req_if.sv
// gmon_req_if: input tick channel, valid/ready with the tick fields
// depends on gmon_pkg
`timescale 1ns / 1ps
`default_nettype none

interface gmon_req_if
   import gmon_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [TIME_W-1:0]   time_ms;
   logic                presence;
   logic [SAMPLE_W-1:0] ammonia_sample;
   logic [SAMPLE_W-1:0] air_sample;

   modport source (output valid, output time_ms, output presence,
                   output ammonia_sample, output air_sample, input ready);
   modport sink (input valid, input time_ms, input presence,
                 input ammonia_sample, input air_sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/gmon_rsp_if.sv
// gmon_rsp_if: result channel, valid/ready with the status and change fields
// depends on gmon_pkg
`timescale 1ns / 1ps
`default_nettype none

interface gmon_rsp_if
   import gmon_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic                     recording_on;
   logic                     post_on;
   logic                     presence_rise;
   logic                     active_mode;
   logic [SAMPLE_W-1:0]      air_filtered;
   logic signed [CHG_W-1:0]  ammonia_change;
   logic [LVL_W-1:0]         ammonia_level;
   logic [ACHG_W-1:0]        air_change;
   logic [LVL_W-1:0]         air_level;
   logic signed [CHG_W-1:0]  led_level;

   modport source (output valid, output recording_on, output post_on,
                   output presence_rise, output active_mode, output air_filtered,
                   output ammonia_change, output ammonia_level, output air_change,
                   output air_level, output led_level, input ready);
   modport sink (input valid, input recording_on, input post_on,
                 input presence_rise, input active_mode, input air_filtered,
                 input ammonia_change, input ammonia_level, input air_change,
                 input air_level, input led_level, output ready);
endinterface

`default_nettype wire

FILE: rtl/gmon_div.sv
// gmon_div: restoring divider, one quotient bit per cycle, with overflow flag
// when the quotient needs more than QUO_W bits; depends on gmon_pkg
`timescale 1ns / 1ps
`default_nettype none

module gmon_div
   import gmon_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [QUO_W-1:0]      quo,
   output logic                  ovf
);
   localparam int unsigned CNT_W = $clog2(QUO_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     low_ff, low_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic                 ovf_ff, ovf_in;
   logic [DEN_W:0]       rem_sh;
   logic [DEN_W:0]       den_ext;
   logic [DEN_W-1:0]     den_ff, den_in;

   assign rem_sh  = {rem_ff, low_ff[QUO_W-1]};
   assign den_ext = {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = den;
         ovf_in  = {1'b0, num} >= {den, {QUO_W{1'b0}}};
         rem_in  = DEN_W'(num[NUM_W-1:QUO_W]);
         low_in  = num[QUO_W-1:0];
         quo_in  = '0;
      end else if (busy_ff) begin
         low_in = {low_ff[QUO_W-2:0], 1'b0};
         if (rem_sh >= den_ext) begin
            rem_in = DEN_W'(rem_sh - den_ext);
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign ovf  = ovf_ff;

endmodule

`default_nettype wire

FILE: rtl/gmon_ctrl.sv
// gmon_ctrl: sequencing state machine for one tick transaction
// depends on gmon_pkg
`timescale 1ns / 1ps
`default_nettype none

module gmon_ctrl
   import gmon_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire dp_status_type status,
   output logic               req_ready,
   output dp_cmd_type         cmd
);
   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_REC;
         ST_REC:   state_in = ST_MODE;
         ST_MODE:  state_in = ST_FMUL;
         ST_FMUL:  state_in = ST_FADD;
         ST_FADD:  state_in = ST_NUM;
         ST_NUM:   state_in = ST_LVL;
         ST_LVL:   state_in = ST_DIVA;
         ST_DIVA:  state_in = ST_WAITA;
         ST_WAITA: if (status.div_done) state_in = ST_DIVB;
         ST_DIVB:  state_in = ST_WAITB;
         ST_WAITB: if (status.div_done) state_in = ST_DONE;
         ST_DONE:  if (status.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         ST_REC:   cmd.rec_upd = 1'b1;
         ST_MODE:  cmd.mode_upd = 1'b1;
         ST_FMUL:  cmd.fmul = 1'b1;
         ST_FADD:  cmd.fadd = 1'b1;
         ST_NUM:   cmd.num = 1'b1;
         ST_LVL:   cmd.lvl = 1'b1;
         ST_DIVA:  cmd.div_start = 1'b1;
         ST_WAITA: cmd.amm_capture = status.div_done;
         ST_DIVB: begin
            cmd.div_start = 1'b1;
            cmd.div_air   = 1'b1;
         end
         ST_WAITB: cmd.div_air = 1'b1;
         ST_DONE:  cmd.out_load = status.out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/gmon_dp.sv
// gmon_dp: configuration registers, recording timers, air filter, change
// arithmetic and result register; depends on gmon_pkg and gmon_div
`timescale 1ns / 1ps
`default_nettype none

module gmon_dp
   import gmon_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dp_cmd_type            cmd,
   output dp_status_type              status,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic [TIME_W-1:0]     in_time_ms,
   input  wire logic                  in_presence,
   input  wire logic [SAMPLE_W-1:0]   in_ammonia_sample,
   input  wire logic [SAMPLE_W-1:0]   in_air_sample,
   input  wire logic                  out_ready,
   output logic                       out_valid,
   output logic                       out_recording_on,
   output logic                       out_post_on,
   output logic                       out_presence_rise,
   output logic                       out_active_mode,
   output logic [SAMPLE_W-1:0]        out_air_filtered,
   output logic signed [CHG_W-1:0]    out_ammonia_change,
   output logic [LVL_W-1:0]           out_ammonia_level,
   output logic [ACHG_W-1:0]          out_air_change,
   output logic [LVL_W-1:0]           out_air_level,
   output logic signed [CHG_W-1:0]    out_led_level
);

   function automatic logic [LVL_W-1:0] level_of(input logic [PROD_W-1:0] n,
                                                 input logic [SAMPLE_W-1:0] b);
      logic [PROD_W-1:0] t1;
      logic [PROD_W-1:0] t2;
      logic [PROD_W-1:0] t3;
      t1 = PROD_W'(b) * PROD_W'(LVL1_K);
      t2 = PROD_W'(b) * PROD_W'(LVL2_K);
      t3 = PROD_W'(b) * PROD_W'(LVL3_K);
      if (n < t1) begin
         level_of = 2'd0;
      end else if (n < t2) begin
         level_of = 2'd1;
      end else if (n < t3) begin
         level_of = 2'd2;
      end else begin
         level_of = 2'd3;
      end
   endfunction

   // configuration registers
   logic [SAMPLE_W-1:0] amm_base_ff, air_base_ff;
   logic [TIME_W-1:0]   ignore_ms_ff, post_ms_ff, boost_ms_ff;
   logic [ALPHA_W-1:0]  act_alpha_ff, idle_alpha_ff;
   logic [FLOOR_W-1:0]  floor_ff;

   // latched transaction
   logic [TIME_W-1:0]   t_ff;
   logic                pres_ff;
   logic [SAMPLE_W-1:0] amm_ff, air_ff;

   // recording and filter state
   logic                rec_ff, rec_in;
   logic                post_ff, post_in;
   logic                prev_ff, prev_in;
   logic [TIME_W-1:0]   start_ff, start_in;
   logic [TIME_W-1:0]   end_ff, end_in;
   logic                rise_ff, rise_in;
   logic                active_ff, active_in;
   logic [SAMPLE_W-1:0] filt_ff, filt_in;

   // working registers
   logic [FSUM_W-1:0]   p1_ff, p2_ff;
   logic                big_ff;
   logic                amm_neg_ff;
   logic [PROD_W-1:0]   amm_a_ff, air_a_ff, air_n_ff;
   logic [NFP_W-1:0]    nfp_ff;
   logic [LVL_W-1:0]    amm_lvl_ff, air_lvl_ff;
   logic [QUO_W-1:0]    amm_q_ff;
   logic                amm_ovf_ff;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     o_rec_ff, o_post_ff, o_rise_ff, o_act_ff;
   logic [SAMPLE_W-1:0]      o_filt_ff;
   logic signed [CHG_W-1:0]  o_amm_chg_ff, o_led_ff;
   logic [LVL_W-1:0]         o_amm_lvl_ff, o_air_lvl_ff;
   logic [ACHG_W-1:0]        o_air_chg_ff;

   logic [TIME_W-1:0]   rec_len;
   logic                expire, boost;
   logic [ALPHA_W-1:0]  alpha_raw, alpha_c, alpha_inv;
   logic [SAMPLE_W-1:0] band, filt_diff;
   logic [FSUM_W-1:0]   fsum;
   logic [SAMPLE_W-1:0] amm_mag, air_mag;
   logic [K_W-1:0]      air_k;
   logic                noise_cut;
   logic [PROD_W-1:0]   air_n;
   logic [NUM_W-1:0]    div_num;
   logic [DEN_W-1:0]    div_den;
   logic                div_done;
   logic [QUO_W-1:0]    div_quo;
   logic                div_ovf;
   logic signed [CHG_W-1:0] amm_chg;
   logic [ACHG_W-1:0]       air_chg;
   logic signed [CHG_W-1:0] air_chg_s;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         amm_base_ff   <= RST_AMM_BASE;
         air_base_ff   <= RST_AIR_BASE;
         ignore_ms_ff  <= RST_IGNORE_MS;
         post_ms_ff    <= RST_POST_MS;
         boost_ms_ff   <= RST_BOOST_MS;
         act_alpha_ff  <= RST_ACT_ALPHA;
         idle_alpha_ff <= RST_IDLE_ALPHA;
         floor_ff      <= RST_NOISE_FLOOR;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_AMM_BASE:    amm_base_ff   <= csr_data[SAMPLE_W-1:0];
            CSR_AIR_BASE:    air_base_ff   <= csr_data[SAMPLE_W-1:0];
            CSR_IGNORE_MS:   ignore_ms_ff  <= csr_data[TIME_W-1:0];
            CSR_POST_MS:     post_ms_ff    <= csr_data[TIME_W-1:0];
            CSR_BOOST_MS:    boost_ms_ff   <= csr_data[TIME_W-1:0];
            CSR_ACT_ALPHA:   act_alpha_ff  <= csr_data[ALPHA_W-1:0];
            CSR_IDLE_ALPHA:  idle_alpha_ff <= csr_data[ALPHA_W-1:0];
            CSR_NOISE_FLOOR: floor_ff      <= csr_data[FLOOR_W-1:0];
            default: ;
         endcase
      end
   end

   // recording state machine and mode
   assign rec_len = t_ff - start_ff;
   assign expire  = post_ff && (t_ff >= end_ff);
   assign boost   = post_ff && !expire &&
                    ((post_ms_ff - (end_ff - t_ff)) < boost_ms_ff);

   always_comb begin
      rec_in    = rec_ff;
      post_in   = post_ff;
      prev_in   = prev_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      rise_in   = rise_ff;
      active_in = active_ff;
      if (cmd.rec_upd) begin
         prev_in = pres_ff;
         rise_in = pres_ff && !prev_ff;
         if (pres_ff) begin
            post_in = 1'b0;
            if (!rec_ff) begin
               rec_in   = 1'b1;
               start_in = t_ff;
            end
         end else if (prev_ff && rec_ff && !post_ff) begin
            if (rec_len >= ignore_ms_ff) begin
               post_in = 1'b1;
               end_in  = t_ff + post_ms_ff;
            end else begin
               rec_in = 1'b0;
            end
         end
      end
      if (cmd.mode_upd) begin
         if (expire) begin
            post_in = 1'b0;
            rec_in  = 1'b0;
         end
         active_in = pres_ff || (rec_ff && !post_ff) || boost;
      end
   end

   // air filter
   assign alpha_raw = active_ff ? act_alpha_ff : idle_alpha_ff;
   assign alpha_c   = (alpha_raw > ALPHA_ONE) ? ALPHA_ONE : alpha_raw;
   assign alpha_inv = ALPHA_ONE - alpha_c;
   assign band      = active_ff ? SAMPLE_W'(ACTIVE_DEADBAND) : SAMPLE_W'(IDLE_DEADBAND);
   assign filt_diff = (air_ff >= filt_ff) ? (air_ff - filt_ff) : (filt_ff - air_ff);
   assign fsum      = p1_ff + p2_ff + FSUM_W'(128);

   always_comb begin
      filt_in = filt_ff;
      if (cmd.fadd) begin
         if (filt_ff == '0) begin
            filt_in = air_ff;
         end else if (big_ff) begin
            filt_in = fsum[SAMPLE_W+7:8];
         end
      end
   end

   // change numerators
   assign amm_mag   = amm_neg_ff ? (amm_base_ff - amm_ff) : (amm_ff - amm_base_ff);
   assign air_mag   = (filt_ff >= air_base_ff) ? (filt_ff - air_base_ff)
                                               : (air_base_ff - filt_ff);
   assign air_k     = active_ff ? ACTIVE_K : IDLE_K;
   assign noise_cut = !active_ff && ({1'b0, air_a_ff} < {nfp_ff, 4'b0000});
   assign air_n     = noise_cut ? '0 : air_a_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         t_ff       <= in_time_ms;
         pres_ff    <= in_presence;
         amm_ff     <= in_ammonia_sample;
         air_ff     <= in_air_sample;
         amm_neg_ff <= in_ammonia_sample < amm_base_ff;
      end
      if (cmd.fmul) begin
         p1_ff  <= FSUM_W'(alpha_c) * FSUM_W'(air_ff);
         p2_ff  <= FSUM_W'(alpha_inv) * FSUM_W'(filt_ff);
         big_ff <= filt_diff > band;
      end
      if (cmd.num) begin
         amm_a_ff <= PROD_W'(amm_mag) * PROD_W'(AMM_K);
         air_a_ff <= PROD_W'(air_mag) * PROD_W'(air_k);
         nfp_ff   <= NFP_W'(floor_ff) * NFP_W'(air_base_ff);
      end
      if (cmd.lvl) begin
         amm_lvl_ff <= amm_neg_ff ? 2'd0 : level_of(amm_a_ff, amm_base_ff);
         air_lvl_ff <= level_of(air_n, air_base_ff);
         air_n_ff   <= air_n;
      end
      if (cmd.amm_capture) begin
         amm_q_ff   <= div_quo;
         amm_ovf_ff <= div_ovf;
      end
   end

   // rounded quotient: (2n + d) / 2d with d = 16 * baseline
   always_comb begin
      if (cmd.div_air) begin
         div_num = NUM_W'({air_n_ff, 1'b0}) + NUM_W'({air_base_ff, 4'b0000});
         div_den = {air_base_ff, 5'b00000};
      end else begin
         div_num = NUM_W'({amm_a_ff, 1'b0}) + NUM_W'({amm_base_ff, 4'b0000});
         div_den = {amm_base_ff, 5'b00000};
      end
   end

   gmon_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .ovf   (div_ovf)
   );

   // saturation and led maximum
   always_comb begin
      if (amm_base_ff == '0) begin
         amm_chg = '0;
      end else if (!amm_neg_ff) begin
         amm_chg = (amm_ovf_ff || amm_q_ff[QUO_W-1]) ? 16'sh7fff : signed'(amm_q_ff);
      end else if (amm_ovf_ff || (amm_q_ff > 16'h8000)) begin
         amm_chg = 16'sh8000;
      end else begin
         amm_chg = signed'(16'h0000 - amm_q_ff);
      end
      if (air_base_ff == '0) begin
         air_chg = '0;
      end else if (div_ovf || div_quo[QUO_W-1]) begin
         air_chg = 15'h7fff;
      end else begin
         air_chg = div_quo[ACHG_W-1:0];
      end
   end

   assign air_chg_s = signed'({1'b0, air_chg});

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         o_rec_ff     <= rec_ff;
         o_post_ff    <= post_ff;
         o_rise_ff    <= rise_ff;
         o_act_ff     <= active_ff;
         o_filt_ff    <= filt_ff;
         o_amm_chg_ff <= amm_chg;
         o_amm_lvl_ff <= (amm_base_ff == '0) ? 2'd0 : amm_lvl_ff;
         o_air_chg_ff <= air_chg;
         o_air_lvl_ff <= (air_base_ff == '0) ? 2'd0 : air_lvl_ff;
         o_led_ff     <= (amm_chg > air_chg_s) ? amm_chg : air_chg_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff       <= 1'b0;
         post_ff      <= 1'b0;
         prev_ff      <= 1'b0;
         start_ff     <= '0;
         end_ff       <= '0;
         rise_ff      <= 1'b0;
         active_ff    <= 1'b0;
         filt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rec_ff       <= rec_in;
         post_ff      <= post_in;
         prev_ff      <= prev_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         rise_ff      <= rise_in;
         active_ff    <= active_in;
         filt_ff      <= filt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || out_ready;

   assign out_valid          = rsp_valid_ff;
   assign out_recording_on   = o_rec_ff;
   assign out_post_on        = o_post_ff;
   assign out_presence_rise  = o_rise_ff;
   assign out_active_mode    = o_act_ff;
   assign out_air_filtered   = o_filt_ff;
   assign out_ammonia_change = o_amm_chg_ff;
   assign out_ammonia_level  = o_amm_lvl_ff;
   assign out_air_change     = o_air_chg_ff;
   assign out_air_level      = o_air_lvl_ff;
   assign out_led_level      = o_led_ff;

endmodule

`default_nettype wire

FILE: rtl/presence_gated_gas_monitor_unit.sv
// presence_gated_gas_monitor_unit: top level, joins gmon_ctrl and gmon_dp
// depends on gmon_pkg, gmon_req_if, gmon_rsp_if, gmon_ctrl, gmon_dp, gmon_div
//
//   channel   direction  handshake          contents
//   req_bus   in         valid/ready        time_ms, presence, two gas samples
//   rsp_bus   out        valid/ready        recording flags, filter, changes, levels
//   csr_*     in         csr_wr_en only     register index and write data
//
// one tick goes from acceptance to the result register through the shared
// 16-step divider, run once per gas channel
// a new tick is taken as soon as the previous one is in the result register,
// even while that result waits for rsp_bus.ready
// synchronous active-high reset clears control state and loads register defaults
`timescale 1ns / 1ps
`default_nettype none

module presence_gated_gas_monitor_unit
   import gmon_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   gmon_req_if.sink                   req_bus,
   gmon_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);
   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;

   assign req_bus.ready = req_ready;

   gmon_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   gmon_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .in_time_ms         (req_bus.time_ms),
      .in_presence        (req_bus.presence),
      .in_ammonia_sample  (req_bus.ammonia_sample),
      .in_air_sample      (req_bus.air_sample),
      .out_ready          (rsp_bus.ready),
      .out_valid          (rsp_bus.valid),
      .out_recording_on   (rsp_bus.recording_on),
      .out_post_on        (rsp_bus.post_on),
      .out_presence_rise  (rsp_bus.presence_rise),
      .out_active_mode    (rsp_bus.active_mode),
      .out_air_filtered   (rsp_bus.air_filtered),
      .out_ammonia_change (rsp_bus.ammonia_change),
      .out_ammonia_level  (rsp_bus.ammonia_level),
      .out_air_change     (rsp_bus.air_change),
      .out_air_level      (rsp_bus.air_level),
      .out_led_level      (rsp_bus.led_level)
   );

endmodule

`default_nettype wire
